/* design/heat_equation_explicit_stencil_unit_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the heat equation stencil unit
// Implication checks with synchronous sampling and reset gating.
// ----------------------------------------------------------------------------
`ifndef HEAT_EQUATION_EXPLICIT_STENCIL_UNIT_ASSERT_SVH
`define HEAT_EQUATION_EXPLICIT_STENCIL_UNIT_ASSERT_SVH

// same-cycle implication
`define HEES_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define HEES_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

/* design/hees_pkg.sv */
// ----------------------------------------------------------------------------
// hees_pkg
// Shared constants and types of the heat equation stencil unit.
// ----------------------------------------------------------------------------
package hees_pkg;

	localparam int MAX_POINTS  = 64;
	localparam int VALUE_WIDTH = 16;
	localparam int COEF_WIDTH  = 16;
	localparam int STEP_WIDTH  = 10;
	localparam int PCNT_WIDTH  = 7;
	localparam int IDX_WIDTH   = $clog2(MAX_POINTS);
	localparam int POS_WIDTH   = $clog2(MAX_POINTS + 1);
	localparam int ADDR_WIDTH  = 4;
	localparam int DATA_WIDTH  = 32;

	// register indexes (paddr[3:2])
	localparam logic [1:0] REG_COEF  = 2'd0;
	localparam logic [1:0] REG_STEPS = 2'd1;
	localparam logic [1:0] REG_PCNT  = 2'd2;

	localparam logic [COEF_WIDTH-1:0] COEF_RESET  = COEF_WIDTH'(32768);
	localparam logic [STEP_WIDTH-1:0] STEPS_RESET = STEP_WIDTH'(20);
	localparam logic [PCNT_WIDTH-1:0] PCNT_RESET  = PCNT_WIDTH'(11);
	localparam logic [PCNT_WIDTH-1:0] PCNT_MIN    = PCNT_WIDTH'(3);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_PREP = 4'b0010,
		ST_STEP = 4'b0100,
		ST_EMIT = 4'b1000
	} state_t;

	// per-cell command
	typedef struct packed {
		logic load;     // write loaded value into both grids
		logic copy;     // fixed end: odd <= even
		logic step;     // interior update this cycle
		logic sel_odd;  // odd grid is the source
	} cell_cmd_t;

endpackage

/* design/heat_equation_explicit_stencil_unit.sv */
// ----------------------------------------------------------------------------
// heat_equation_explicit_stencil_unit
// 1-D explicit heat equation solver on a row of grid-point cells.
// ----------------------------------------------------------------------------
// Usage:
//  - Input transaction: start high while busy is low. Each one stores
//    point_value at the next grid slot (slots past MAX_POINTS are dropped).
//    A plain point leaves busy low.
//  - The transaction with load_last high ends the load: busy rises until
//    all n points (n = point_count clamped to 3..64) are read out. The PREP
//    state copies the fixed ends, then every cell updates in parallel, one
//    time step per clock, then one point is read out per clock.
//  - Results: point k (0..n-1) is strobed by result_valid for one cycle,
//    in index order from a register after the time steps. result_last
//    marks point n-1. The receiver cannot stall; results are never held.
//  - Config: APB port, coefficient at 0x0, step count at 0x4, point count
//    at 0x8. Write only while busy is low and no results are pending.
//  - Reset (arst_n low) returns to idle, clears the load slot and restores
//    register defaults; grid contents are undefined until loaded.
// ----------------------------------------------------------------------------
`include "heat_equation_explicit_stencil_unit_assert.svh"

module heat_equation_explicit_stencil_unit (
	input  logic                                     clk,
	input  logic                                     arst_n,
	// APB configuration port
	input  logic                                     psel,
	input  logic                                     penable,
	input  logic                                     pwrite,
	input  logic [hees_pkg::ADDR_WIDTH-1:0]          paddr,
	input  logic [hees_pkg::DATA_WIDTH-1:0]          pwdata,
	output logic [hees_pkg::DATA_WIDTH-1:0]          prdata,
	output logic                                     pready,
	// command channel
	input  logic                                     start,
	output logic                                     busy,
	input  logic signed [hees_pkg::VALUE_WIDTH-1:0]  point_value,
	input  logic                                     load_last,
	// result channel
	output logic                                     result_valid,
	output logic        [hees_pkg::IDX_WIDTH-1:0]    point_index,
	output logic signed [hees_pkg::VALUE_WIDTH-1:0]  result_value,
	output logic                                     result_last
);

	localparam int N  = hees_pkg::MAX_POINTS;
	localparam int PW = hees_pkg::POS_WIDTH;
	localparam int VW = hees_pkg::VALUE_WIDTH;
	localparam int SW = hees_pkg::STEP_WIDTH;
	localparam int CW = hees_pkg::PCNT_WIDTH;

	// configuration registers
	logic [hees_pkg::COEF_WIDTH-1:0] coef_q;
	logic [SW-1:0]                   steps_q;
	logic [CW-1:0]                   pcnt_q;

	hees_pkg::state_t state_q;
	logic [PW-1:0]    load_pos_q;
	logic [SW-1:0]    step_q;
	logic [hees_pkg::IDX_WIDTH-1:0] emit_idx_q;

	logic          accept;
	logic          cfg_wr;
	logic [1:0]    reg_idx;
	logic [CW-1:0] n_clamp;
	logic [PW-1:0] n_last;    // index of the right fixed end
	logic          src_odd;

	hees_pkg::cell_cmd_t     cmd  [N];
	logic signed [VW-1:0]    vals [N];

	assign accept  = start && !busy;
	assign busy    = (state_q != hees_pkg::ST_IDLE);
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign reg_idx = paddr[3:2];

	// clamp point count to 3..MAX_POINTS
	always_comb begin
		if (pcnt_q < hees_pkg::PCNT_MIN) begin
			n_clamp = hees_pkg::PCNT_MIN;
		end else if (pcnt_q > CW'(N)) begin
			n_clamp = CW'(N);
		end else begin
			n_clamp = pcnt_q;
		end
	end
	assign n_last = PW'(n_clamp - CW'(1));

	// during stepping the source grid alternates; at readout it is the last one written
	assign src_odd = (state_q == hees_pkg::ST_EMIT) ? steps_q[0] : step_q[0];

	// config write and read back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q  <= hees_pkg::COEF_RESET;
			steps_q <= hees_pkg::STEPS_RESET;
			pcnt_q  <= hees_pkg::PCNT_RESET;
		end else if (cfg_wr) begin
			case (reg_idx)
				hees_pkg::REG_COEF:  coef_q  <= pwdata[hees_pkg::COEF_WIDTH-1:0];
				hees_pkg::REG_STEPS: steps_q <= pwdata[SW-1:0];
				hees_pkg::REG_PCNT:  pcnt_q  <= pwdata[CW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			hees_pkg::REG_COEF:  prdata = hees_pkg::DATA_WIDTH'(coef_q);
			hees_pkg::REG_STEPS: prdata = hees_pkg::DATA_WIDTH'(steps_q);
			hees_pkg::REG_PCNT:  prdata = hees_pkg::DATA_WIDTH'(pcnt_q);
			default:             prdata = '0;
		endcase
	end

	// sequencer: idle/load -> copy ends -> time steps (none if step count is 0) -> readout
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= hees_pkg::ST_IDLE;
			load_pos_q <= '0;
			step_q     <= '0;
			emit_idx_q <= '0;
		end else begin
			case (state_q)
				hees_pkg::ST_IDLE: begin
					if (accept) begin
						if (load_last) begin
							load_pos_q <= '0;
							state_q    <= hees_pkg::ST_PREP;
						end else if (load_pos_q < PW'(N)) begin
							load_pos_q <= load_pos_q + PW'(1);
						end
					end
				end
				hees_pkg::ST_PREP: begin
					step_q     <= '0;
					emit_idx_q <= '0;
					state_q    <= (steps_q == '0) ? hees_pkg::ST_EMIT : hees_pkg::ST_STEP;
				end
				hees_pkg::ST_STEP: begin
					step_q <= step_q + SW'(1);
					if (step_q + SW'(1) == steps_q) begin
						state_q <= hees_pkg::ST_EMIT;
					end
				end
				hees_pkg::ST_EMIT: begin
					emit_idx_q <= emit_idx_q + hees_pkg::IDX_WIDTH'(1);
					if (PW'(emit_idx_q) == n_last) begin
						state_q <= hees_pkg::ST_IDLE;
					end
				end
				default: state_q <= hees_pkg::ST_IDLE;
			endcase
		end
	end

	// row of cells, each talking to its two neighbors
	for (genvar j = 0; j < N; j++) begin : g_cell
		logic signed [VW-1:0] left_v, right_v;

		assign cmd[j].load    = accept && (load_pos_q == PW'(j));
		assign cmd[j].copy    = (state_q == hees_pkg::ST_PREP) &&
		                        ((j == 0) || (PW'(j) == n_last));
		assign cmd[j].step    = (state_q == hees_pkg::ST_STEP) && (j != 0) &&
		                        (PW'(j) < n_last);
		assign cmd[j].sel_odd = src_odd;

		if (j == 0) begin : g_lend
			assign left_v = '0;
		end else begin : g_lmid
			assign left_v = vals[j-1];
		end
		if (j == N - 1) begin : g_rend
			assign right_v = '0;
		end else begin : g_rmid
			assign right_v = vals[j+1];
		end

		hees_cell u_cell (
			.clk        (clk),
			.cmd        (cmd[j]),
			.coef       (coef_q),
			.load_value (point_value),
			.left       (left_v),
			.right      (right_v),
			.value      (vals[j])
		);
	end

	// registered readout
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else begin
			result_valid <= (state_q == hees_pkg::ST_EMIT);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == hees_pkg::ST_EMIT) begin
			point_index  <= emit_idx_q;
			result_value <= vals[emit_idx_q];
			result_last  <= (PW'(emit_idx_q) == n_last);
		end
	end

	// ------------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------------
	`HEES_ASSERT_NEXT(a_last_ends_burst, clk, arst_n, result_valid && result_last, !result_valid)
	`HEES_ASSERT_NEXT(a_index_counts, clk, arst_n, result_valid && !result_last, result_valid && (point_index == $past(point_index) + 1'b1))
	`HEES_ASSERT_NEXT(a_run_starts, clk, arst_n, accept && load_last, busy && (state_q == hees_pkg::ST_PREP))
	`HEES_ASSERT_NOW(a_step_bound, clk, arst_n, state_q == hees_pkg::ST_STEP, step_q < steps_q)

endmodule

/* design/hees_cell.sv */
// ----------------------------------------------------------------------------
// hees_cell
// One grid point: even/odd values and the FTCS update from its neighbors.
// ----------------------------------------------------------------------------
module hees_cell (
	input  logic                                    clk,
	input  hees_pkg::cell_cmd_t                     cmd,
	input  logic        [hees_pkg::COEF_WIDTH-1:0]  coef,
	input  logic signed [hees_pkg::VALUE_WIDTH-1:0] load_value,
	input  logic signed [hees_pkg::VALUE_WIDTH-1:0] left,
	input  logic signed [hees_pkg::VALUE_WIDTH-1:0] right,
	output logic signed [hees_pkg::VALUE_WIDTH-1:0] value
);

	localparam int VW      = hees_pkg::VALUE_WIDTH;
	localparam int LAP_W   = VW + 2;
	localparam int PROD_W  = LAP_W + hees_pkg::COEF_WIDTH + 1;
	localparam int DELTA_W = PROD_W - hees_pkg::COEF_WIDTH;
	localparam int SUM_W   = DELTA_W + 1;
	localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'((2 ** (VW - 1)) - 1);
	localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - SUM_W'(1);
	localparam logic signed [PROD_W-1:0] HALF = PROD_W'(2 ** (hees_pkg::COEF_WIDTH - 1));

	logic signed [VW-1:0]      even_q, odd_q;
	logic signed [LAP_W-1:0]   lap;
	logic signed [PROD_W-1:0]  prod, rnd;
	logic signed [DELTA_W-1:0] delta;
	logic signed [SUM_W-1:0]   sum;
	logic signed [VW-1:0]      next_val;

	assign value = cmd.sel_odd ? odd_q : even_q;

	assign lap   = LAP_W'(left) + LAP_W'(right) - (LAP_W'(value) <<< 1);
	assign prod  = PROD_W'($signed({1'b0, coef})) * PROD_W'(lap);
	assign rnd   = prod + HALF;
	assign delta = rnd[PROD_W-1:hees_pkg::COEF_WIDTH];
	assign sum   = SUM_W'(value) + SUM_W'(delta);

	always_comb begin
		if (sum > SAT_HI) begin
			next_val = SAT_HI[VW-1:0];
		end else if (sum < SAT_LO) begin
			next_val = SAT_LO[VW-1:0];
		end else begin
			next_val = sum[VW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			even_q <= load_value;
			odd_q  <= load_value;
		end else if (cmd.copy) begin
			odd_q <= even_q;
		end else if (cmd.step) begin
			if (cmd.sel_odd) begin
				even_q <= next_val;
			end else begin
				odd_q <= next_val;
			end
		end
	end

endmodule
